### rtl/search_frontier_priority_queue_core_assert.svh
// assertion macros for the search frontier queue
`ifndef SEARCH_FRONTIER_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SEARCH_FRONTIER_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SFPQ_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define SFPQ_ASSERT_CLK(label, prop, msg)
`define SFPQ_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/sfpq_pkg.sv
`default_nettype none
package sfpq_pkg;

  localparam int unsigned TAG_W      = 16;
  localparam int unsigned KEY_PORT_W = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ORDER_FIFO  = 2'd0;
  localparam logic [1:0] ORDER_HEUR  = 2'd1;
  localparam logic [1:0] ORDER_ASTAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic [1:0] order;
  } sfpq_ctrl_t;

endpackage
`default_nettype wire

### rtl/sfpq_cell.sv
`default_nettype none
module sfpq_cell #(
  parameter int KW = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire sfpq_pkg::sfpq_ctrl_t    ctrl,
  input  wire [sfpq_pkg::TAG_W-1:0]    new_tag,
  input  wire [KW-1:0]                 new_h,
  input  wire [KW-1:0]                 new_g,
  input  wire [KW:0]                   new_sum,
  input  wire                          found_in,
  input  wire                          prev_valid,
  input  wire [sfpq_pkg::TAG_W-1:0]    prev_tag,
  input  wire [KW-1:0]                 prev_h,
  input  wire [KW-1:0]                 prev_g,
  input  wire                          next_valid,
  input  wire [sfpq_pkg::TAG_W-1:0]    next_tag,
  input  wire [KW-1:0]                 next_h,
  input  wire [KW-1:0]                 next_g,
  output logic                         found_out,
  output logic                         valid,
  output logic [sfpq_pkg::TAG_W-1:0]   tag,
  output logic [KW-1:0]                h,
  output logic [KW-1:0]                g
);

  logic          ahead;
  logic          stop;
  logic [KW:0]   sum;

  assign sum = {1'b0, h} + {1'b0, g};

  always_comb begin
    unique case (ctrl.order)
      sfpq_pkg::ORDER_HEUR: begin
        ahead = valid && (h > new_h);
      end
      sfpq_pkg::ORDER_ASTAR: begin
        ahead = valid && ((sum > new_sum) || ((sum == new_sum) && (g <= new_g)));
      end
      default: begin
        ahead = 1'b0;
      end
    endcase
  end

  // first cell that is ahead-of or empty takes the new entry
  assign stop      = ahead || !valid;
  assign found_out = found_in || stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (found_in) begin
        valid <= prev_valid;
      end else if (stop) begin
        valid <= 1'b1;
      end
    end else if (ctrl.rem) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (found_in) begin
        tag <= prev_tag;
        h   <= prev_h;
        g   <= prev_g;
      end else if (stop) begin
        tag <= new_tag;
        h   <= new_h;
        g   <= new_g;
      end
    end else if (ctrl.rem) begin
      tag <= next_tag;
      h   <= next_h;
      g   <= next_g;
    end
  end

endmodule
`default_nettype wire

### rtl/search_frontier_priority_queue_core.sv
// Sorted search-frontier queue built as a row of QUEUE_DEPTH cells, head in
// cell zero. One request (insert or remove head) is taken every clock
// cycle and busy is never raised. Its result appears on the result ports
// in the cycle after start, for that cycle only, marked by done; the receiver
// cannot stall, so it must take every result as it comes. The row keeps this
// rate because every cell compares its entry with the new one and shifts
// toward its neighbour in the same cycle. The insert order (fifo, heuristic,
// a-star) comes from cfg_wdata, written with cfg_we while no request is
// outstanding.
`default_nettype none
`include "search_frontier_priority_queue_core_assert.svh"
module search_frontier_priority_queue_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int KEY_WIDTH   = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [1:0]                         cfg_wdata,
  input  wire                                start,
  output logic                               busy,
  input  wire                                mode,
  input  wire  [sfpq_pkg::TAG_W-1:0]         item_tag,
  input  wire  [sfpq_pkg::KEY_PORT_W-1:0]    key_h,
  input  wire  [sfpq_pkg::KEY_PORT_W-1:0]    key_g,
  output logic                               done,
  output logic [sfpq_pkg::STATUS_W-1:0]      status,
  output logic [sfpq_pkg::TAG_W-1:0]         out_tag,
  output logic [sfpq_pkg::KEY_PORT_W-1:0]    out_h,
  output logic [sfpq_pkg::KEY_PORT_W-1:0]    out_g,
  output logic [sfpq_pkg::COUNT_W-1:0]       count
);

  localparam int KW = (KEY_WIDTH < sfpq_pkg::KEY_PORT_W) ? KEY_WIDTH : sfpq_pkg::KEY_PORT_W;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = sfpq_pkg::TAG_W;

  logic [1:0]            order_mode;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [CW+6:0]         cnt_ext;
  logic                  accept;
  logic                  full;
  logic                  empty;
  sfpq_pkg::sfpq_ctrl_t  ctrl;
  logic [KW-1:0]         new_h;
  logic [KW-1:0]         new_g;
  logic [KW:0]           new_sum;

  logic [QUEUE_DEPTH-1:0]  cell_valid;
  logic [QUEUE_DEPTH:0]    found;
  logic [TW-1:0]           cell_tag [QUEUE_DEPTH];
  logic [KW-1:0]           cell_h   [QUEUE_DEPTH];
  logic [KW-1:0]           cell_g   [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt == CW'(QUEUE_DEPTH));
  assign empty  = (cnt == '0);

  assign new_h   = key_h[KW-1:0];
  assign new_g   = key_g[KW-1:0];
  assign new_sum = {1'b0, new_h} + {1'b0, new_g};

  assign ctrl.ins   = accept && (mode == sfpq_pkg::MODE_INSERT) && !full;
  assign ctrl.rem   = accept && (mode == sfpq_pkg::MODE_REMOVE) && !empty;
  assign ctrl.order = order_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= sfpq_pkg::ORDER_FIFO;
    end else if (cfg_we) begin
      order_mode <= cfg_wdata;
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + 1'b1;
    end else if (ctrl.rem) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic          pv;
    logic [TW-1:0] pt;
    logic [KW-1:0] ph;
    logic [KW-1:0] pg;
    logic          nv;
    logic [TW-1:0] nt;
    logic [KW-1:0] nh;
    logic [KW-1:0] ng;

    if (i == 0) begin : g_first
      assign pv = 1'b0;
      assign pt = '0;
      assign ph = '0;
      assign pg = '0;
    end else begin : g_mid
      assign pv = cell_valid[i-1];
      assign pt = cell_tag[i-1];
      assign ph = cell_h[i-1];
      assign pg = cell_g[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign nt = '0;
      assign nh = '0;
      assign ng = '0;
    end else begin : g_inner
      assign nv = cell_valid[i+1];
      assign nt = cell_tag[i+1];
      assign nh = cell_h[i+1];
      assign ng = cell_g[i+1];
    end

    sfpq_cell #(
      .KW(KW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_tag    (item_tag),
      .new_h      (new_h),
      .new_g      (new_g),
      .new_sum    (new_sum),
      .found_in   (found[i]),
      .prev_valid (pv),
      .prev_tag   (pt),
      .prev_h     (ph),
      .prev_g     (pg),
      .next_valid (nv),
      .next_tag   (nt),
      .next_h     (nh),
      .next_g     (ng),
      .found_out  (found[i+1]),
      .valid      (cell_valid[i]),
      .tag        (cell_tag[i]),
      .h          (cell_h[i]),
      .g          (cell_g[i])
    );
  end

  assign cnt_ext = {7'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= sfpq_pkg::STATUS_OK;
      out_tag <= '0;
      out_h   <= '0;
      out_g   <= '0;
      count   <= cnt_ext[sfpq_pkg::COUNT_W-1:0];
      if (mode == sfpq_pkg::MODE_REMOVE) begin
        if (empty) begin
          status <= sfpq_pkg::STATUS_EMPTY;
        end else begin
          out_tag <= cell_tag[0];
          out_h   <= sfpq_pkg::KEY_PORT_W'(cell_h[0]);
          out_g   <= sfpq_pkg::KEY_PORT_W'(cell_g[0]);
        end
      end else if (full) begin
        status <= sfpq_pkg::STATUS_FULL;
      end
    end
  end

  `SFPQ_ASSERT_NEXT(a_done_follows_start, start, done, "request gave no result")
  `SFPQ_ASSERT_CLK(a_valid_matches_count, $countones(cell_valid) == int'(cnt), "valid vs count")
  `SFPQ_ASSERT_CLK(a_head_valid, cell_valid[0] == !empty, "head validity vs count")
  `SFPQ_ASSERT_NEXT(a_insert_counts, ctrl.ins, cnt == CW'($past(cnt) + 1'b1), "insert count")

endmodule
`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfpq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int KEY_WIDTH      = 16;
  localparam int PLAN_ROWS      = 27;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 234;
  localparam int QUIET_TAIL     = 150;
  localparam int LAST_QUIET     = PLAN_ROWS + PHASES * PHASE_ITEMS - QUIET_TAIL;
  localparam int WATCHDOG_LIMIT = 200;

  localparam logic [1:0] ORDER_SPARE = 2'd3;
  localparam logic [KEY_PORT_W-1:0] KEY_MASK = {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - KEY_WIDTH);
  // phase 0 sits in the low bits
  localparam logic [2*PHASES-1:0] PHASE_ORDERS = {ORDER_FIFO, ORDER_ASTAR, ORDER_HEUR,
    ORDER_ASTAR, ORDER_FIFO, ORDER_SPARE, ORDER_ASTAR, ORDER_HEUR};

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [KEY_PORT_W-1:0] h;
    logic [KEY_PORT_W-1:0] g;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [TAG_W-1:0]      tag;
    logic [KEY_PORT_W-1:0] h;
    logic [KEY_PORT_W-1:0] g;
    logic [COUNT_W-1:0]    count;
  } result_t;

  typedef struct packed {
    logic [1:0]            ord;
    logic                  op;
    logic [TAG_W-1:0]      tag;
    logic [KEY_PORT_W-1:0] h;
    logic [KEY_PORT_W-1:0] g;
    logic                  pinned;
    result_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_wdata;
  logic                  start;
  logic                  busy;
  logic                  mode;
  logic [TAG_W-1:0]      item_tag;
  logic [KEY_PORT_W-1:0] key_h;
  logic [KEY_PORT_W-1:0] key_g;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [TAG_W-1:0]      out_tag;
  logic [KEY_PORT_W-1:0] out_h;
  logic [KEY_PORT_W-1:0] out_g;
  logic [COUNT_W-1:0]    count;

  entry_t    frontier[$];
  result_t   pending_results[$];
  logic [1:0] order_q;
  logic       pin_valid;
  result_t    pin_result;
  plan_row_t  plan [PLAN_ROWS];
  int         items_sent;
  int         results_checked;
  int         full_hits;
  int         empty_hits;
  int         errors;
  int         stall_cycles;

  search_frontier_priority_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .item_tag (item_tag),
    .key_h    (key_h),
    .key_g    (key_g),
    .done     (done),
    .status   (status),
    .out_tag  (out_tag),
    .out_h    (out_h),
    .out_g    (out_g),
    .count    (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit ranks_ahead(entry_t e, logic [KEY_PORT_W-1:0] h,
                                     logic [KEY_PORT_W-1:0] g);
    logic [KEY_PORT_W:0] held_sum;
    logic [KEY_PORT_W:0] new_sum;
    held_sum = {1'b0, e.h} + {1'b0, e.g};
    new_sum  = {1'b0, h} + {1'b0, g};
    case (order_q)
      ORDER_HEUR: return e.h > h;
      ORDER_ASTAR: return (held_sum > new_sum) || (held_sum == new_sum && e.g <= g);
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t frontier_step(logic op, logic [TAG_W-1:0] tag,
                                            logic [KEY_PORT_W-1:0] h,
                                            logic [KEY_PORT_W-1:0] g);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    r.status = STATUS_OK;
    if (op == MODE_REMOVE) begin
      if (frontier.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        e = frontier.pop_front();
        r.tag = e.tag;
        r.h = e.h;
        r.g = e.g;
      end
    end else if (frontier.size() >= QUEUE_DEPTH) begin
      r.status = STATUS_FULL;
    end else begin
      e.tag = tag;
      e.h = h & KEY_MASK;
      e.g = g & KEY_MASK;
      pos = 0;
      while (pos < frontier.size() && !ranks_ahead(frontier[pos], e.h, e.g)) pos++;
      frontier.insert(pos, e);
    end
    r.count = COUNT_W'(frontier.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s at %0t ns: got %0h, expected %0h", field, $time, got, want);
    errors++;
  endtask

  // result check first, then the request taken at this edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      frontier.delete();
      pending_results.delete();
      order_q = ORDER_FIFO;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", 16'(status), 16'h0);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (status !== want.status) report_mismatch("status", 16'(status), 16'(want.status));
          if (out_tag !== want.tag) report_mismatch("out_tag", out_tag, want.tag);
          if (out_h !== want.h) report_mismatch("out_h", out_h, want.h);
          if (out_g !== want.g) report_mismatch("out_g", out_g, want.g);
          if (count !== want.count) report_mismatch("count", 16'(count), 16'(want.count));
        end
      end
      if (cfg_we) order_q = cfg_wdata;
      if (start && !busy) begin
        want = frontier_step(mode, item_tag, key_h, key_g);
        if (pin_valid) want = pin_result;
        if (want.status == STATUS_FULL) full_hits++;
        if (want.status == STATUS_EMPTY) empty_hits++;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", stall_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // every driver task starts and ends at a falling edge
  task automatic send(logic op, logic [TAG_W-1:0] tag, logic [KEY_PORT_W-1:0] h,
                      logic [KEY_PORT_W-1:0] g, logic pinned, result_t pres);
    start = 1'b1;
    mode = op;
    item_tag = tag;
    key_h = h;
    key_g = g;
    pin_valid = pinned;
    pin_result = pres;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_order(logic [1:0] ord);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = ord;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [KEY_PORT_W-1:0] rand_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    // small keys make ties common
    if (pick < 4) return KEY_PORT_W'($urandom_range(0, 7));
    if (pick == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (pick == 5) return KEY_PORT_W'(16'hffff - $urandom_range(0, 3));
    return KEY_PORT_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(logic op, bit calm);
    if (!calm && items_sent < LAST_QUIET && $urandom_range(0, 5) == 0)
      idle_for($urandom_range(1, 8));
    send(op, TAG_W'($urandom_range(0, 65535)), rand_key(), rand_key(), 1'b0, '0);
  endtask

  task automatic random_phase(int n_items);
    int target;
    int kind;
    bit calm;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      if (kind < 3) begin
        // fill to the brim and push past it
        while (frontier.size() < QUEUE_DEPTH) send_random(MODE_INSERT, calm);
        repeat ($urandom_range(1, 3)) send_random(MODE_INSERT, calm);
      end else if (kind < 5) begin
        while (frontier.size() != 0) send_random(MODE_REMOVE, calm);
        repeat ($urandom_range(1, 3)) send_random(MODE_REMOVE, calm);
      end else begin
        if (kind == 5 && items_sent < LAST_QUIET) settle();
        repeat ($urandom_range(4, 40))
          send_random(($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_REMOVE, calm);
      end
    end
  endtask

  initial begin
    logic [1:0] cur_order;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = ORDER_FIFO;
    start = 1'b0;
    mode = MODE_INSERT;
    item_tag = '0;
    key_h = '0;
    key_g = '0;
    pin_valid = 1'b0;
    pin_result = '0;
    items_sent = 0;
    results_checked = 0;
    full_hits = 0;
    empty_hits = 0;
    errors = 0;
    stall_cycles = 0;
    plan = '{
      '{ORDER_FIFO, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b1,
        '{STATUS_EMPTY, 16'h0, 16'h0, 16'h0, 7'd0}},
      '{ORDER_FIFO, MODE_INSERT, 16'hffff, 16'hffff, 16'hffff, 1'b1,
        '{STATUS_OK, 16'h0, 16'h0, 16'h0, 7'd1}},
      '{ORDER_FIFO, MODE_INSERT, 16'h0, 16'h0, 16'h0, 1'b1,
        '{STATUS_OK, 16'h0, 16'h0, 16'h0, 7'd2}},
      '{ORDER_FIFO, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b1,
        '{STATUS_OK, 16'hffff, 16'hffff, 16'hffff, 7'd1}},
      '{ORDER_FIFO, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b1,
        '{STATUS_OK, 16'h0, 16'h0, 16'h0, 7'd0}},
      // heuristic order, equal h goes behind
      '{ORDER_HEUR, MODE_INSERT, 16'd1, 16'd5, 16'd0, 1'b0, '0},
      '{ORDER_HEUR, MODE_INSERT, 16'd2, 16'd3, 16'd9, 1'b0, '0},
      '{ORDER_HEUR, MODE_INSERT, 16'd3, 16'd5, 16'd1, 1'b0, '0},
      '{ORDER_HEUR, MODE_INSERT, 16'd4, 16'hffff, 16'd0, 1'b0, '0},
      '{ORDER_HEUR, MODE_INSERT, 16'd5, 16'd0, 16'hffff, 1'b0, '0},
      '{ORDER_HEUR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_HEUR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_HEUR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_HEUR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_HEUR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      // a-star: equal sums, larger cost first, same cost new one first
      '{ORDER_ASTAR, MODE_INSERT, 16'd6, 16'd4, 16'd6, 1'b0, '0},
      '{ORDER_ASTAR, MODE_INSERT, 16'd7, 16'd6, 16'd4, 1'b0, '0},
      '{ORDER_ASTAR, MODE_INSERT, 16'd8, 16'd2, 16'd8, 1'b0, '0},
      '{ORDER_ASTAR, MODE_INSERT, 16'd9, 16'd4, 16'd6, 1'b0, '0},
      '{ORDER_ASTAR, MODE_INSERT, 16'd10, 16'hffff, 16'hffff, 1'b0, '0},
      '{ORDER_ASTAR, MODE_INSERT, 16'd11, 16'd1, 16'd1, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0},
      '{ORDER_ASTAR, MODE_REMOVE, 16'h0, 16'h0, 16'h0, 1'b0, '0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cur_order = ORDER_FIFO;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].ord != cur_order) begin
        set_order(plan[i].ord);
        cur_order = plan[i].ord;
      end
      send(plan[i].op, plan[i].tag, plan[i].h, plan[i].g, plan[i].pinned, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_order(PHASE_ORDERS[2*p +: 2]);
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (3) @(posedge clk);
    $display("%0d requests over all four order settings, %0d results checked",
             items_sent, results_checked);
    $display("%0d inserts on a full queue, %0d removes on an empty one",
             full_hits, empty_hits);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
